/* hdl/eec_pkg.sv */
// ----------------------------------------------------------------------------
// eec_pkg: shared types and constants for the energy error clamp core
// Request/result payload structs, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package eec_pkg;

    localparam int SpeedW  = 16;
    localparam int AltW    = 20;
    localparam int ErrW    = 48;
    localparam int CfgW    = 16;
    localparam int CfgIdxW = 2;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_MASS      = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_WEIGHT    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MIN_SPEED = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_MAX_SPEED = 2'd3;

    localparam logic [CfgW-1:0] MASS_DEFAULT  = 16'd640;
    localparam logic [CfgW-1:0] MASS_MIN      = 16'd3;
    localparam logic [CfgW-1:0] WEIGHT_MAX    = 16'd32768;
    localparam logic [CfgW-1:0] WEIGHT_RESET  = 16'd0;
    localparam logic [CfgW-1:0] MIN_SPD_RESET = 16'd0;
    localparam logic [CfgW-1:0] MAX_SPD_RESET = 16'd65535;

    // g = 10043 / 1024
    localparam logic [13:0] G_NUM = 14'd10043;

    typedef struct packed {
        logic        [SpeedW-1:0] ref_speed;
        logic        [SpeedW-1:0] meas_speed;
        logic signed [AltW-1:0]   ref_altitude;
        logic signed [AltW-1:0]   meas_altitude;
    } sample_t;

    typedef struct packed {
        logic signed [ErrW-1:0] total_error;
        logic signed [ErrW-1:0] balance_error;
    } result_t;

endpackage

/* hdl/energy_error_clamp_core.sv */
// ----------------------------------------------------------------------------
// energy_error_clamp_core: total energy control error stage
// Kinetic and potential energy errors, total error capped at the max-speed
// bound, weighted balance error clamped to the speed-limit kinetic range.
// ----------------------------------------------------------------------------
// Seven register stages lie between request accept and result_valid.
// Throughput: one request per cycle while the result side takes results; the multiplier stages set the depth.
// Stages hand off independently, so an empty stage takes a request while the
//   output register still holds a result.
// Reset clears all stage valids and loads the configuration reset values.
module energy_error_clamp_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  eec_pkg::sample_t                sample,
    output logic                            result_valid,
    input  logic                            result_ready,
    output eec_pkg::result_t                result,
    input  logic                            cfg_wr_en,
    input  logic [eec_pkg::CfgIdxW-1:0]     cfg_addr,
    input  logic [eec_pkg::CfgW-1:0]        cfg_wdata
);
    import eec_pkg::*;

    // configuration
    logic [CfgW-1:0] mass_reg;
    logic [CfgW-1:0] weight_reg;
    logic [CfgW-1:0] min_speed_reg;
    logic [CfgW-1:0] max_speed_reg;
    logic [CfgW-1:0] mass_eff;

    // stage control
    logic [6:0] v_reg;
    logic [6:0] en;

    // stage 1
    logic        [31:0] mv_r_reg, mv_m_reg, mv_lo_reg, mv_hi_reg;
    logic        [15:0] vr1_reg, vm1_reg, vlo1_reg, vhi1_reg;
    logic        [29:0] mg_reg;
    logic signed [20:0] dh_reg;
    logic signed [20:0] dh_next;

    // stage 2
    logic        [47:0] kp_r_reg, kp_m_reg, kp_lo_reg, kp_hi_reg;
    logic signed [51:0] pp_reg;
    logic signed [51:0] pp_next;

    // stage 3
    logic        [31:0] k_r_reg, k_m_reg, k_lo_reg, k_hi_reg;
    logic signed [37:0] pot_reg;
    logic signed [51:0] pot_sum;

    // stage 4
    logic signed [32:0] kerr_reg, minerr4_reg, maxerr4_reg;
    logic signed [37:0] pot4_reg;
    logic signed [38:0] total4_reg;

    // stage 5
    logic signed [55:0] pa_reg, pb_reg;
    logic signed [32:0] minerr5_reg, maxerr5_reg;
    logic signed [38:0] total5_reg;
    logic        [15:0] wcomp;

    // stage 6
    logic signed [41:0] bal6_reg;
    logic signed [32:0] minerr6_reg, maxerr6_reg;
    logic signed [38:0] total6_reg;
    logic signed [55:0] bsum;

    // stage 7 clamp
    logic signed [41:0] bal_lo, bal_cl, min42, max42;
    logic signed [38:0] total_cl, max39;
    result_t            result_reg;

    // ------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg      <= MASS_DEFAULT;
            weight_reg    <= WEIGHT_RESET;
            min_speed_reg <= MIN_SPD_RESET;
            max_speed_reg <= MAX_SPD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_MASS:      mass_reg      <= cfg_wdata;
                REG_WEIGHT:    weight_reg    <= (cfg_wdata > WEIGHT_MAX) ? WEIGHT_MAX
                                                                          : cfg_wdata;
                REG_MIN_SPEED: min_speed_reg <= cfg_wdata;
                REG_MAX_SPEED: max_speed_reg <= cfg_wdata;
                default:       mass_reg      <= mass_reg;
            endcase
        end
    end

    // replace a tiny mass by the default
    assign mass_eff = (mass_reg < MASS_MIN) ? MASS_DEFAULT : mass_reg;

    // ------------------------------------------------------------------
    // stage handoff: a stage loads when it is empty or its content moves on
    always_comb
    begin
        en[6] = !v_reg[6] || result_ready;
        for (int k = 5; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign sample_ready = en[0];
    assign result_valid = v_reg[6];
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= sample_valid;
            for (int k = 1; k < 7; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: mass times speed, mass times g, height difference
    assign dh_next = 21'(sample.ref_altitude) - 21'(sample.meas_altitude);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mv_r_reg  <= 32'(mass_eff) * 32'(sample.ref_speed);
            mv_m_reg  <= 32'(mass_eff) * 32'(sample.meas_speed);
            mv_lo_reg <= 32'(mass_eff) * 32'(min_speed_reg);
            mv_hi_reg <= 32'(mass_eff) * 32'(max_speed_reg);
            vr1_reg   <= sample.ref_speed;
            vm1_reg   <= sample.meas_speed;
            vlo1_reg  <= min_speed_reg;
            vhi1_reg  <= max_speed_reg;
            mg_reg    <= 30'(mass_eff) * 30'(G_NUM);
            dh_reg    <= dh_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: second speed factor, potential product
    assign pp_next = 52'(signed'({1'b0, mg_reg})) * 52'(dh_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            kp_r_reg  <= 48'(mv_r_reg) * 48'(vr1_reg);
            kp_m_reg  <= 48'(mv_m_reg) * 48'(vm1_reg);
            kp_lo_reg <= 48'(mv_lo_reg) * 48'(vlo1_reg);
            kp_hi_reg <= 48'(mv_hi_reg) * 48'(vhi1_reg);
            pp_reg    <= pp_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: round to Q.8 joules (add half, floor)
    assign pot_sum = pp_reg + 52'sd8192;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            k_r_reg  <= 32'((49'(kp_r_reg)  + 49'd65536) >> 17);
            k_m_reg  <= 32'((49'(kp_m_reg)  + 49'd65536) >> 17);
            k_lo_reg <= 32'((49'(kp_lo_reg) + 49'd65536) >> 17);
            k_hi_reg <= 32'((49'(kp_hi_reg) + 49'd65536) >> 17);
            pot_reg  <= pot_sum[51:14];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: errors relative to the measured kinetic energy
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            kerr_reg    <= signed'({1'b0, k_r_reg})  - signed'({1'b0, k_m_reg});
            minerr4_reg <= signed'({1'b0, k_lo_reg}) - signed'({1'b0, k_m_reg});
            maxerr4_reg <= signed'({1'b0, k_hi_reg}) - signed'({1'b0, k_m_reg});
            pot4_reg    <= pot_reg;
            total4_reg  <= 39'(pot_reg) + 39'(signed'({1'b0, k_r_reg}))
                           - 39'(signed'({1'b0, k_m_reg}));
        end
    end

    // ------------------------------------------------------------------
    // stage 5: weighted products
    assign wcomp = WEIGHT_MAX - weight_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            pa_reg      <= 56'(signed'({1'b0, wcomp})) * 56'(kerr_reg);
            pb_reg      <= 56'(signed'({1'b0, weight_reg})) * 56'(pot4_reg);
            minerr5_reg <= minerr4_reg;
            maxerr5_reg <= maxerr4_reg;
            total5_reg  <= total4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: balance difference, round from Q2.14
    assign bsum = pa_reg - pb_reg + 56'sd8192;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            bal6_reg    <= bsum[55:14];
            minerr6_reg <= minerr5_reg;
            maxerr6_reg <= maxerr5_reg;
            total6_reg  <= total5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: clamp; raise to the lower bound first so the upper bound wins
    always_comb
    begin
        min42    = 42'(minerr6_reg);
        max42    = 42'(maxerr6_reg);
        max39    = 39'(maxerr6_reg);
        bal_lo   = (bal6_reg < min42) ? min42 : bal6_reg;
        bal_cl   = (bal_lo > max42) ? max42 : bal_lo;
        total_cl = (total6_reg > max39) ? max39 : total6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            result_reg.total_error   <= ErrW'(total_cl);
            result_reg.balance_error <= ErrW'(bal_cl);
        end
    end

    // ------------------------------------------------------------------
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        weight_reg <= WEIGHT_MAX)
        else $error("balance weight register above 2.0");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> v_reg[0])
        else $error("accepted request missing from first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[5] && !en[5] |=> v_reg[5] && $stable(bal6_reg))
        else $error("stalled balance stage lost or changed its request");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> sample_ready)
        else $error("empty first stage refused a request");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for energy_error_clamp_core
// Sends speed/altitude requests over valid/ready, predicts the total and
// balance energy errors from a local copy of the config registers, and checks
// every result in order. A short directed table comes first, then random
// requests across several register settings, with random gaps on both sides
// and one long result stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eec_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int PIPE_DEPTH       = 7;
    localparam int RANDOM_PHASES    = 7;
    localparam int REQS_PER_PHASE   = 100;
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef enum logic {STEP_REQ, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t       kind;
        logic [CfgIdxW-1:0] addr;
        logic [CfgW-1:0]  data;
        sample_t          req;
        bit               typed;
        result_t          want;
    } plan_step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    sample_t sample = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0] cfg_addr = '0;
    logic [CfgW-1:0] cfg_wdata = '0;

    // local copy of the config registers
    logic [CfgW-1:0] mass_reg = MASS_DEFAULT;
    logic [CfgW-1:0] weight_reg = WEIGHT_RESET;
    logic [CfgW-1:0] min_speed_reg = MIN_SPD_RESET;
    logic [CfgW-1:0] max_speed_reg = MAX_SPD_RESET;

    result_t pending_errors[$];
    plan_step_t directed_steps[$];
    int error_count = 0;
    int results_seen = 0;
    int cycle_count = 0;

    energy_error_clamp_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // kinetic energy in Q.8 J, round half up
    function automatic longint kin_q8(longint m, longint v);
        return (m * v * v + 65536) >>> 17;
    endfunction

    function automatic logic [ErrW-1:0] clip48(longint x);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (ErrW - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            x = hi;
        if (x < lo)
            x = lo;
        return x[ErrW-1:0];
    endfunction

    function automatic result_t predict_energy_errors(sample_t s);
        longint m;
        longint w;
        longint kin_meas;
        longint kin_err;
        longint pot_err;
        longint lo_err;
        longint hi_err;
        longint total;
        longint bal;
        result_t r;
        m = (mass_reg < MASS_MIN) ? longint'(MASS_DEFAULT) : longint'(mass_reg);
        w = longint'(weight_reg);
        kin_meas = kin_q8(m, longint'(s.meas_speed));
        kin_err = kin_q8(m, longint'(s.ref_speed)) - kin_meas;
        pot_err = (m * longint'(G_NUM) * (longint'($signed(s.ref_altitude))
                  - longint'($signed(s.meas_altitude))) + 8192) >>> 14;
        lo_err = kin_q8(m, longint'(min_speed_reg)) - kin_meas;
        hi_err = kin_q8(m, longint'(max_speed_reg)) - kin_meas;
        total = pot_err + kin_err;
        bal = ((longint'(32768) - w) * kin_err - w * pot_err + 8192) >>> 14;
        // raise first, then lower: with inverted limits the upper bound wins
        if (bal < lo_err)
            bal = lo_err;
        if (bal > hi_err)
            bal = hi_err;
        if (total > hi_err)
            total = hi_err;
        r.total_error = clip48(total);
        r.balance_error = clip48(bal);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // zero, all ones, top bit only, all but top bit, or anything
    function automatic int corner(int bits);
        int full;
        full = (1 << bits) - 1;
        case ($urandom_range(0, 5))
            0: return 0;
            1: return full;
            2: return 1 << (bits - 1);
            3: return full >> 1;
            default: return $urandom_range(0, full);
        endcase
    endfunction

    function automatic sample_t random_request();
        sample_t s;
        case ($urandom_range(0, 3))
            2:
            begin
                // close readings keep results inside the speed limits
                s.ref_speed = 16'($urandom_range(0, 65535));
                s.meas_speed = 16'(s.ref_speed + $urandom_range(0, 1024) - 512);
                s.ref_altitude = 20'($urandom_range(0, 20'hFFFFF));
                s.meas_altitude = 20'(s.ref_altitude + $urandom_range(0, 256) - 128);
            end
            3:
            begin
                s.ref_speed = 16'(corner(SpeedW));
                s.meas_speed = 16'(corner(SpeedW));
                s.ref_altitude = 20'(corner(AltW));
                s.meas_altitude = 20'(corner(AltW));
            end
            default:
            begin
                s.ref_speed = 16'($urandom_range(0, 65535));
                s.meas_speed = 16'($urandom_range(0, 65535));
                s.ref_altitude = 20'($urandom_range(0, 20'hFFFFF));
                s.meas_altitude = 20'($urandom_range(0, 20'hFFFFF));
            end
        endcase
        return s;
    endfunction

    function automatic void plan_req(int vr, int vm, int hr, int hm,
                                     bit typed, longint tot, longint bal);
        plan_step_t p;
        p.kind = STEP_REQ;
        p.addr = '0;
        p.data = '0;
        p.req.ref_speed = vr[15:0];
        p.req.meas_speed = vm[15:0];
        p.req.ref_altitude = hr[19:0];
        p.req.meas_altitude = hm[19:0];
        p.typed = typed;
        p.want.total_error = tot[ErrW-1:0];
        p.want.balance_error = bal[ErrW-1:0];
        directed_steps.push_back(p);
    endfunction

    function automatic void plan_write(logic [CfgIdxW-1:0] addr, int data);
        plan_step_t p;
        p.kind = STEP_WRITE;
        p.addr = addr;
        p.data = data[15:0];
        p.req = '0;
        p.typed = 1'b0;
        p.want = '0;
        directed_steps.push_back(p);
    endfunction

    // called at a rising edge; returns at a rising edge
    task automatic send_request(input sample_t s, input result_t want, input bit typed,
                                input int gap);
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(negedge clk);
        while (!sample_ready);
        @(posedge clk);
        pending_errors.push_back(typed ? want : predict_energy_errors(s));
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_errors.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] addr, input logic [CfgW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_MASS:      mass_reg = data;
            REG_WEIGHT:    weight_reg = (data > WEIGHT_MAX) ? WEIGHT_MAX : data;
            REG_MIN_SPEED: min_speed_reg = data;
            REG_MAX_SPEED: max_speed_reg = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // result side: random ready pattern plus one long hold-off
    initial
    begin : drive_result_ready
        int run;
        int gap;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_seen >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 8);
                result_ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    always @(negedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (pending_errors.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: total %0d balance %0d",
                             result.total_error, result.balance_error);
            end
            else
            begin
                want = pending_errors.pop_front();
                if (result.total_error !== want.total_error ||
                    result.balance_error !== want.balance_error)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch %0d: total %0d exp %0d, balance %0d exp %0d",
                                 results_seen, result.total_error, want.total_error,
                                 result.balance_error, want.balance_error);
                end
            end
        end
    end

    initial
    begin : stimulus
        plan_step_t p;
        sample_t s;
        logic [CfgW-1:0] m;
        logic [CfgW-1:0] w;
        logic [CfgW-1:0] lo;
        logic [CfgW-1:0] hi;
        bit no_gaps;

        // reset registers: mass 2.5 kg, weight 0, speed limits full range
        plan_req(0, 0, 0, 0, 1, 0, 0);
        plan_req(256, 0, 0, 0, 1, 320, 640);
        plan_req(65535, 0, 524287, -524288, 0, 0, 0);
        plan_req(0, 65535, -524288, 524287, 0, 0, 0);
        plan_req(65535, 65535, 0, 0, 1, 0, 0);
        plan_req(0, 65535, 0, 0, 0, 0, 0);
        plan_write(REG_WEIGHT, 16384);
        plan_req(1000, 3000, 1600, -1600, 0, 0, 0);
        plan_req(16'h5555, 16'hAAAA, 20'h55555, 20'hAAAAA, 0, 0, 0);
        // weight above 2.0 saturates
        plan_write(REG_WEIGHT, 65535);
        plan_req(16'hAAAA, 16'h5555, 20'hAAAAA, 20'h55555, 0, 0, 0);
        // tiny mass falls back to 2.5 kg
        plan_write(REG_MASS, 0);
        plan_req(256, 0, 0, 0, 1, 320, 0);
        plan_write(REG_MASS, 2);
        plan_req(256, 0, 0, 0, 1, 320, 0);
        // smallest mass used as is; 1.5 LSB rounds up
        plan_write(REG_MASS, 3);
        plan_req(256, 0, 0, 0, 1, 2, 0);
        plan_write(REG_MASS, 65535);
        plan_req(65535, 0, 524287, -524288, 0, 0, 0);
        plan_req(0, 65535, -524288, 524287, 0, 0, 0);
        // inverted speed limits: upper bound wins
        plan_write(REG_MASS, 640);
        plan_write(REG_WEIGHT, 0);
        plan_write(REG_MIN_SPEED, 512);
        plan_write(REG_MAX_SPEED, 256);
        plan_req(0, 0, 0, 0, 1, 0, 320);
        plan_req(300, 100, 16, 0, 0, 0, 0);
        plan_write(REG_MIN_SPEED, 0);
        plan_write(REG_MAX_SPEED, 0);
        plan_req(65535, 0, 524287, 0, 0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            p = directed_steps[i];
            if (p.kind == STEP_WRITE)
            begin
                drain();
                write_reg(p.addr, p.data);
            end
            else
                send_request(p.req, p.want, p.typed, pick_gap());
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    m = 16'hFFFF;
                    w = WEIGHT_MAX;
                    lo = 16'h0000;
                    hi = 16'hFFFF;
                end
                1:
                begin
                    m = MASS_MIN;
                    w = 16'h0000;
                    lo = 16'hFFFF;
                    hi = 16'h0000;
                end
                default:
                begin
                    m = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                                    : 16'($urandom_range(0, 65535));
                    case ($urandom_range(0, 3))
                        0: w = 16'h0000;
                        1: w = WEIGHT_MAX;
                        2: w = 16'($urandom_range(32769, 65535));
                        default: w = 16'($urandom_range(0, 32768));
                    endcase
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            lo = 16'h0000;
                            hi = 16'hFFFF;
                        end
                        1:
                        begin
                            lo = 16'($urandom_range(0, 20000));
                            hi = 16'($urandom_range(30000, 65535));
                        end
                        default:
                        begin
                            lo = 16'($urandom_range(0, 65535));
                            hi = 16'($urandom_range(0, 65535));
                        end
                    endcase
                end
            endcase
            drain();
            write_reg(REG_MASS, m);
            write_reg(REG_WEIGHT, w);
            write_reg(REG_MIN_SPEED, lo);
            write_reg(REG_MAX_SPEED, hi);

            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < REQS_PER_PHASE; n++)
            begin
                s = random_request();
                send_request(s, '0, 1'b0, no_gaps ? 0 : pick_gap());
            end
        end

        drain();
        repeat (PIPE_DEPTH * 3) @(posedge clk);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/eec_pkg.sv
hdl/energy_error_clamp_core.sv
test/tb_top.sv
